[src/optical_flow_frame_receiver_assert.svh]
// ----------------------------------------------------------------------------
// Optical flow frame receiver assertion macros
// Clocked assertion forms shared by the receiver RTL, with an empty variant.
// ----------------------------------------------------------------------------
`ifndef OPTICAL_FLOW_FRAME_RECEIVER_ASSERT_SVH
`define OPTICAL_FLOW_FRAME_RECEIVER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off while in reset.
`define OFR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk, off while in reset.
`define OFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define OFR_ASSERT_NOW(lbl, ante, cons, msg)
`define OFR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[src/ofr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Optical flow frame receiver package
// Frame constants, parser phases, status codes and register indexes.
// ----------------------------------------------------------------------------
package ofr_pkg;

	// Frame bytes and function codes.
	localparam logic [7:0] HDR_BYTE = 8'hAA;
	localparam logic [7:0] FN_FLOW  = 8'h51;
	localparam logic [7:0] FN_ALT   = 8'h52;
	localparam logic [7:0] SEL_RAW  = 8'h00;
	localparam logic [7:0] SEL_FUSED = 8'h01;

	// Payload capture depth and its index width.
	localparam int CAP_DEPTH = 15;
	localparam int CAP_IDX_W = $clog2(CAP_DEPTH);

	// Silence age limits and register reset values.
	localparam logic [13:0] AGE_RESET       = 14'd10000;
	localparam logic [13:0] AGE_MAX         = 14'd16383;
	localparam logic [7:0]  SOURCE_RESET    = 8'h22;
	localparam logic [13:0] TIMEOUT_RESET   = 14'd1000;
	localparam logic [13:0] CEILING_RESET   = 14'd10000;

	// Configuration register indexes.
	localparam logic [1:0] CFG_EXPECTED_SOURCE = 2'd0;
	localparam logic [1:0] CFG_TIMEOUT_MS      = 2'd1;
	localparam logic [1:0] CFG_AGE_CEILING     = 2'd2;

	// Parser phases.
	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_SRC     = 3'd1,
		PH_DST     = 3'd2,
		PH_FUNC    = 3'd3,
		PH_LEN     = 3'd4,
		PH_PAYLOAD = 3'd5,
		PH_CSUM    = 3'd6
	} phase_t;

	// Per-beat frame status.
	typedef enum logic [1:0] {
		ST_NONE = 2'd0,
		ST_OK   = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	// Request kinds carried on tuser.
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

endpackage

`default_nettype wire

[src/optical_flow_frame_receiver.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Optical flow frame receiver
// Parses 0xAA-framed sensor frames with an additive checksum and ages two
// liveness counters on millisecond ticks; one result beat per input beat.
// ----------------------------------------------------------------------------
// Path: an accepted beat is held in the input register, then goes through the
// parse/update logic into the result register.
// Throughput: one beat per cycle; the input register and the result register
// both advance whenever the result register is empty or being taken.
// Reset: arst_n clears the parser to idle, all latched fields to zero, both ages
// to 10000, sensor_ok to zero and the registers to their default values.
`include "optical_flow_frame_receiver_assert.svh"

module optical_flow_frame_receiver (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Configuration write port.
	input  wire logic         cfg_en,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [13:0]  cfg_data,
	// Input stream.
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [15:0]  s_tdata,  // byte_value[7:0], tick_ms[15:8]
	input  wire logic         s_tuser,  // req_type
	// Result stream.
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// flow_quality[7:0], light_level[15:8], raw_dx[23:16], raw_dy[31:24],
	// fused_dx[47:32], fused_dy[63:48], corrected_dx[79:64],
	// corrected_dy[95:80], raw_altitude[111:96], fused_altitude[127:112],
	// sensor_ok[128], frame_status[130:129], zero fill[135:131]
	output logic [135:0]      m_tdata
);
	import ofr_pkg::*;

	// Configuration registers.
	logic [7:0]  expected_source_q;
	logic [13:0] timeout_ms_q;
	logic [13:0] age_ceiling_q;

	// Input stage.
	logic        valid_s1;
	logic        req_type_s1;
	logic [7:0]  byte_value_s1;
	logic [7:0]  tick_ms_s1;

	// Result stage.
	logic        valid_s2;
	status_t     frame_status_s2;
	logic        adv;

	// Parser state.
	phase_t      phase_q, phase_d;
	logic [7:0]  bytes_left_q, bytes_left_d;
	logic [7:0]  payload_index_q, payload_index_d;
	logic [7:0]  running_sum_q, running_sum_d;
	logic [7:0]  function_code_q, function_code_d;
	logic [7:0]  capture_q [CAP_DEPTH];
	logic [7:0]  capture_d [CAP_DEPTH];

	// Liveness state.
	logic        seen_q [2];
	logic        seen_d [2];
	logic [13:0] age_q [2];
	logic [13:0] age_d [2];
	logic [14:0] age_sum [2];
	logic        ok_q, ok_d;

	// Latched fields.
	logic [7:0]         flow_quality_q, flow_quality_d;
	logic [7:0]         light_level_q, light_level_d;
	logic signed [7:0]  raw_dx_q, raw_dx_d;
	logic signed [7:0]  raw_dy_q, raw_dy_d;
	logic signed [15:0] fused_dx_q, fused_dx_d;
	logic signed [15:0] fused_dy_q, fused_dy_d;
	logic signed [15:0] corrected_dx_q, corrected_dx_d;
	logic signed [15:0] corrected_dy_q, corrected_dy_d;
	logic [15:0]        raw_altitude_q, raw_altitude_d;
	logic [15:0]        fused_altitude_q, fused_altitude_d;
	status_t            status_d;

	// Handshake: the input stage moves on whenever the result register frees up.
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = valid_s2;

	// The latched state changes only when a result is loaded, so it is the result.
	assign m_tdata = {5'b0, frame_status_s2, ok_q, fused_altitude_q, raw_altitude_q,
		corrected_dy_q, corrected_dx_q, fused_dy_q, fused_dx_q, raw_dy_q, raw_dx_q,
		light_level_q, flow_quality_q};

	// Configuration writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_source_q <= SOURCE_RESET;
			timeout_ms_q      <= TIMEOUT_RESET;
			age_ceiling_q     <= CEILING_RESET;
		end else if (cfg_en) begin
			unique case (cfg_index)
				CFG_EXPECTED_SOURCE: expected_source_q <= cfg_data[7:0];
				CFG_TIMEOUT_MS:      timeout_ms_q      <= cfg_data;
				CFG_AGE_CEILING:     age_ceiling_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_type_s1   <= s_tuser;
			byte_value_s1 <= s_tdata[7:0];
			tick_ms_s1    <= s_tdata[15:8];
		end
	end

	// Saturating age sums for the tick path.
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			age_sum[i] = {1'b0, age_q[i]} + {7'b0, tick_ms_s1};
		end
	end

	// Next state for one beat: byte parsing or tick aging.
	always_comb begin
		phase_d          = phase_q;
		bytes_left_d     = bytes_left_q;
		payload_index_d  = payload_index_q;
		running_sum_d    = running_sum_q;
		function_code_d  = function_code_q;
		capture_d        = capture_q;
		seen_d           = seen_q;
		age_d            = age_q;
		ok_d             = ok_q;
		flow_quality_d   = flow_quality_q;
		light_level_d    = light_level_q;
		raw_dx_d         = raw_dx_q;
		raw_dy_d         = raw_dy_q;
		fused_dx_d       = fused_dx_q;
		fused_dy_d       = fused_dy_q;
		corrected_dx_d   = corrected_dx_q;
		corrected_dy_d   = corrected_dy_q;
		raw_altitude_d   = raw_altitude_q;
		fused_altitude_d = fused_altitude_q;
		status_d         = ST_NONE;

		if (req_type_s1 == REQ_BYTE) begin
			priority if (phase_q == PH_IDLE && byte_value_s1 == HDR_BYTE) begin
				// Frame start clears the capture so short payloads read as zero.
				for (int i = 0; i < CAP_DEPTH; i++) begin
					capture_d[i] = 8'h00;
				end
				running_sum_d = byte_value_s1;
				phase_d       = PH_SRC;
			end else if (phase_q == PH_SRC && byte_value_s1 == expected_source_q) begin
				running_sum_d = running_sum_q + byte_value_s1;
				phase_d       = PH_DST;
			end else if (phase_q == PH_DST) begin
				running_sum_d = running_sum_q + byte_value_s1;
				phase_d       = PH_FUNC;
			end else if (phase_q == PH_FUNC) begin
				running_sum_d   = running_sum_q + byte_value_s1;
				function_code_d = byte_value_s1;
				phase_d         = PH_LEN;
			end else if (phase_q == PH_LEN) begin
				running_sum_d   = running_sum_q + byte_value_s1;
				bytes_left_d    = byte_value_s1;
				payload_index_d = 8'h00;
				phase_d         = PH_PAYLOAD;
			end else if (phase_q == PH_PAYLOAD && bytes_left_q != 8'h00) begin
				// Bytes past the capture depth are summed but not stored.
				running_sum_d = running_sum_q + byte_value_s1;
				if (payload_index_q < 8'(CAP_DEPTH)) begin
					capture_d[payload_index_q[CAP_IDX_W-1:0]] = byte_value_s1;
				end
				payload_index_d = payload_index_q + 8'd1;
				bytes_left_d    = bytes_left_q - 8'd1;
				if (bytes_left_q == 8'd1) begin
					phase_d = PH_CSUM;
				end
			end else if (phase_q == PH_CSUM) begin
				phase_d = PH_IDLE;
				if (running_sum_q == byte_value_s1) begin
					status_d = ST_OK;
					// Apply the frame by function code and selector byte.
					if (function_code_q == FN_FLOW) begin
						if (capture_q[0] == SEL_RAW) begin
							flow_quality_d = capture_q[1];
							raw_dx_d       = capture_q[2];
							raw_dy_d       = capture_q[3];
							light_level_d  = capture_q[4];
						end else if (capture_q[0] == SEL_FUSED) begin
							flow_quality_d = capture_q[1];
							fused_dx_d     = {capture_q[2], capture_q[3]};
							fused_dy_d     = {capture_q[4], capture_q[5]};
							corrected_dx_d = {capture_q[6], capture_q[7]};
							corrected_dy_d = {capture_q[8], capture_q[9]};
							light_level_d  = capture_q[14];
							seen_d[0]      = 1'b1;
						end
					end else if (function_code_q == FN_ALT) begin
						if (capture_q[0] == SEL_RAW) begin
							raw_altitude_d = {capture_q[1], capture_q[2]};
							seen_d[1]      = 1'b1;
						end else if (capture_q[0] == SEL_FUSED) begin
							fused_altitude_d = {capture_q[1], capture_q[2]};
						end
					end
				end else begin
					status_d = ST_BAD;
				end
			end else begin
				// Unexpected byte or zero length: drop back to idle.
				phase_d = PH_IDLE;
			end
		end else begin
			// Tick: reset ages that saw data, age the rest up to the ceiling.
			for (int i = 0; i < 2; i++) begin
				if (!seen_q[i]) begin
					if (age_q[i] < age_ceiling_q) begin
						age_d[i] = age_sum[i][14] ? AGE_MAX : age_sum[i][13:0];
					end
				end else begin
					age_d[i] = 14'd0;
				end
				seen_d[i] = 1'b0;
			end
			ok_d = !(age_d[0] > timeout_ms_q || age_d[1] > timeout_ms_q);
		end
	end

	// State update, one beat per load of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_IDLE;
			bytes_left_q     <= 8'h00;
			payload_index_q  <= 8'h00;
			running_sum_q    <= 8'h00;
			function_code_q  <= 8'h00;
			for (int i = 0; i < CAP_DEPTH; i++) begin
				capture_q[i] <= 8'h00;
			end
			for (int i = 0; i < 2; i++) begin
				seen_q[i] <= 1'b0;
				age_q[i]  <= AGE_RESET;
			end
			ok_q             <= 1'b0;
			flow_quality_q   <= 8'h00;
			light_level_q    <= 8'h00;
			raw_dx_q         <= 8'sh00;
			raw_dy_q         <= 8'sh00;
			fused_dx_q       <= 16'sh0000;
			fused_dy_q       <= 16'sh0000;
			corrected_dx_q   <= 16'sh0000;
			corrected_dy_q   <= 16'sh0000;
			raw_altitude_q   <= 16'h0000;
			fused_altitude_q <= 16'h0000;
		end else if (adv) begin
			phase_q          <= phase_d;
			bytes_left_q     <= bytes_left_d;
			payload_index_q  <= payload_index_d;
			running_sum_q    <= running_sum_d;
			function_code_q  <= function_code_d;
			capture_q        <= capture_d;
			seen_q           <= seen_d;
			age_q            <= age_d;
			ok_q             <= ok_d;
			flow_quality_q   <= flow_quality_d;
			light_level_q    <= light_level_d;
			raw_dx_q         <= raw_dx_d;
			raw_dy_q         <= raw_dy_d;
			fused_dx_q       <= fused_dx_d;
			fused_dy_q       <= fused_dy_d;
			corrected_dx_q   <= corrected_dx_d;
			corrected_dy_q   <= corrected_dy_d;
			raw_altitude_q   <= raw_altitude_d;
			fused_altitude_q <= fused_altitude_d;
		end
	end

	// Result register valid and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2        <= 1'b0;
			frame_status_s2 <= ST_NONE;
		end else if (adv) begin
			valid_s2        <= 1'b1;
			frame_status_s2 <= status_d;
		end else if (m_tready) begin
			valid_s2        <= 1'b0;
		end
	end

	// A checksum verdict always ends the frame.
	`OFR_ASSERT_NEXT(a_status_ends_frame, adv && status_d != ST_NONE, phase_q == PH_IDLE, "frame status reported but parser not idle")
	// A tick result never carries a frame status.
	`OFR_ASSERT_NEXT(a_tick_no_status, adv && req_type_s1 == REQ_TICK, frame_status_s2 == ST_NONE, "tick produced a frame status")
	// A tick consumes both liveness flags.
	`OFR_ASSERT_NEXT(a_tick_clears_seen, adv && req_type_s1 == REQ_TICK, !seen_q[0] && !seen_q[1], "seen flags survived a tick")
	// After a tick, sensor ok agrees with the new ages and the timeout.
	`OFR_ASSERT_NEXT(a_ok_matches_ages, adv && req_type_s1 == REQ_TICK, ok_q == !(age_q[0] > timeout_ms_q || age_q[1] > timeout_ms_q), "sensor ok disagrees with the ages after a tick")

endmodule

`default_nettype wire

[tb/sv/ofr_frame_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Optical flow frame receiver checker
// Monitors the configuration port and both streams. It keeps its own copy of
// the frame parser, the latched sensor fields and the silence ages. Each
// accepted input beat adds one expected report, and each result beat is
// checked field by field against the oldest report still outstanding.
// ----------------------------------------------------------------------------
module ofr_frame_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_en,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [13:0]  cfg_data,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [15:0]  s_tdata,  // byte_value[7:0], tick_ms[15:8]
	input  wire logic         s_tuser,  // req_type
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [135:0] m_tdata,  // report fields from bit 0 up, zero fill above 130
	output int                error_count,
	output int                reports_due,
	output int                reports_checked,
	output int                frames_ok,
	output int                frames_bad,
	output int                ok_reports
);
	import ofr_pkg::*;

	localparam int MAX_REPORTS = 10;

	// One result beat; the last member sits in the lowest bits.
	typedef struct packed {
		status_t            frame_status;
		logic               sensor_ok;
		logic [15:0]        fused_altitude;
		logic [15:0]        raw_altitude;
		logic signed [15:0] corrected_dy;
		logic signed [15:0] corrected_dx;
		logic signed [15:0] fused_dy;
		logic signed [15:0] fused_dx;
		logic signed [7:0]  raw_dy;
		logic signed [7:0]  raw_dx;
		logic [7:0]         light_level;
		logic [7:0]         flow_quality;
	} sensor_report_t;

	// Register copies.
	logic [7:0]     src_cfg;
	logic [13:0]    timeout_cfg;
	logic [13:0]    ceiling_cfg;

	// Parser and sensor state.
	phase_t         parse_ph;
	logic [7:0]     bytes_due;
	logic [7:0]     cap_idx;
	logic [7:0]     csum_acc;
	logic [7:0]     fn_code;
	logic [7:0]     captured [CAP_DEPTH];
	logic           flow_seen;
	logic           alt_seen;
	logic [13:0]    flow_age;
	logic [13:0]    alt_age;
	logic           ok_now;
	sensor_report_t latched;

	sensor_report_t pending_reports [$];
	sensor_report_t want_rep;
	sensor_report_t got_rep;
	sensor_report_t fresh_rep;

	// A silence age after one tick: cleared when the kind was seen, else it grows
	// by the tick until it reaches the ceiling, saturating at the 14-bit maximum.
	function automatic logic [13:0] aged(input logic [13:0] age, input logic seen,
			input logic [7:0] dt);
		logic [14:0] grown;
		grown = {1'b0, age} + {7'd0, dt};
		if (seen)
			return '0;
		if (age >= ceiling_cfg)
			return age;
		return (grown > {1'b0, AGE_MAX}) ? AGE_MAX : grown[13:0];
	endfunction

	// Advance the parser or the ages by one input beat and form the report.
	task automatic compute_sensor_report(input logic req, input logic [15:0] data,
			output sensor_report_t rep);
		status_t    st;
		logic [7:0] b;
		logic [7:0] sel;
		st = ST_NONE;
		b = data[7:0];
		if (req == REQ_TICK) begin
			flow_age = aged(flow_age, flow_seen, data[15:8]);
			alt_age = aged(alt_age, alt_seen, data[15:8]);
			flow_seen = 1'b0;
			alt_seen = 1'b0;
			ok_now = !(flow_age > timeout_cfg || alt_age > timeout_cfg);
		end else if (parse_ph == PH_IDLE && b == HDR_BYTE) begin
			for (int i = 0; i < CAP_DEPTH; i++)
				captured[i] = '0;
			csum_acc = b;
			parse_ph = PH_SRC;
		end else if (parse_ph == PH_SRC && b == src_cfg) begin
			csum_acc += b;
			parse_ph = PH_DST;
		end else if (parse_ph == PH_DST) begin
			csum_acc += b;
			parse_ph = PH_FUNC;
		end else if (parse_ph == PH_FUNC) begin
			csum_acc += b;
			fn_code = b;
			parse_ph = PH_LEN;
		end else if (parse_ph == PH_LEN) begin
			csum_acc += b;
			bytes_due = b;
			cap_idx = '0;
			parse_ph = PH_PAYLOAD;
		end else if (parse_ph == PH_PAYLOAD && bytes_due != 0) begin
			// Bytes past the capture depth still count toward the checksum.
			csum_acc += b;
			if (cap_idx < CAP_DEPTH)
				captured[cap_idx] = b;
			cap_idx++;
			bytes_due--;
			if (bytes_due == 0)
				parse_ph = PH_CSUM;
		end else if (parse_ph == PH_CSUM) begin
			parse_ph = PH_IDLE;
			sel = captured[0];
			if (csum_acc != b) begin
				st = ST_BAD;
			end else begin
				st = ST_OK;
				if (fn_code == FN_FLOW && sel == SEL_RAW) begin
					latched.flow_quality = captured[1];
					latched.raw_dx = captured[2];
					latched.raw_dy = captured[3];
					latched.light_level = captured[4];
				end else if (fn_code == FN_FLOW && sel == SEL_FUSED) begin
					latched.flow_quality = captured[1];
					latched.fused_dx = {captured[2], captured[3]};
					latched.fused_dy = {captured[4], captured[5]};
					latched.corrected_dx = {captured[6], captured[7]};
					latched.corrected_dy = {captured[8], captured[9]};
					latched.light_level = captured[14];
					flow_seen = 1'b1;
				end else if (fn_code == FN_ALT && sel == SEL_RAW) begin
					latched.raw_altitude = {captured[1], captured[2]};
					alt_seen = 1'b1;
				end else if (fn_code == FN_ALT && sel == SEL_FUSED) begin
					latched.fused_altitude = {captured[1], captured[2]};
				end
			end
		end else begin
			// Any byte that does not fit the phase is dropped along with the frame.
			parse_ph = PH_IDLE;
		end
		latched.frame_status = st;
		latched.sensor_ok = ok_now;
		rep = latched;
	endtask

	task automatic flag_mismatch(input string what);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic compare_field(input string fname, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got)
			flag_mismatch($sformatf("result %0d %s expected 0x%0h, got 0x%0h",
				reports_checked, fname, want, got));
	endtask

	// Prediction and comparison, one pass per clock edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_cfg = SOURCE_RESET;
			timeout_cfg = TIMEOUT_RESET;
			ceiling_cfg = CEILING_RESET;
			parse_ph = PH_IDLE;
			bytes_due = '0;
			cap_idx = '0;
			csum_acc = '0;
			fn_code = '0;
			for (int i = 0; i < CAP_DEPTH; i++)
				captured[i] = '0;
			flow_seen = 1'b0;
			alt_seen = 1'b0;
			flow_age = AGE_RESET;
			alt_age = AGE_RESET;
			ok_now = 1'b0;
			latched = '0;
			pending_reports.delete();
			error_count = 0;
			reports_checked = 0;
			frames_ok = 0;
			frames_bad = 0;
			ok_reports = 0;
		end else begin
			// A result beat is matched against the oldest outstanding report.
			if (m_tvalid && m_tready) begin
				reports_checked++;
				got_rep = m_tdata[130:0];
				if (pending_reports.size() == 0) begin
					flag_mismatch($sformatf("result beat %0d arrived with nothing expected",
						reports_checked));
				end else begin
					want_rep = pending_reports.pop_front();
					compare_field("flow_quality", want_rep.flow_quality, got_rep.flow_quality);
					compare_field("light_level", want_rep.light_level, got_rep.light_level);
					compare_field("raw_dx", want_rep.raw_dx, got_rep.raw_dx);
					compare_field("raw_dy", want_rep.raw_dy, got_rep.raw_dy);
					compare_field("fused_dx", want_rep.fused_dx, got_rep.fused_dx);
					compare_field("fused_dy", want_rep.fused_dy, got_rep.fused_dy);
					compare_field("corrected_dx", want_rep.corrected_dx, got_rep.corrected_dx);
					compare_field("corrected_dy", want_rep.corrected_dy, got_rep.corrected_dy);
					compare_field("raw_altitude", want_rep.raw_altitude, got_rep.raw_altitude);
					compare_field("fused_altitude", want_rep.fused_altitude,
						got_rep.fused_altitude);
					compare_field("sensor_ok", want_rep.sensor_ok, got_rep.sensor_ok);
					compare_field("frame_status", want_rep.frame_status, got_rep.frame_status);
					compare_field("zero fill", 16'd0, m_tdata[135:131]);
					if (want_rep.frame_status == ST_OK)
						frames_ok++;
					else if (want_rep.frame_status == ST_BAD)
						frames_bad++;
					if (want_rep.sensor_ok)
						ok_reports++;
				end
			end
			// Register writes take effect at the edge they are seen on.
			if (cfg_en) begin
				case (cfg_index)
					CFG_EXPECTED_SOURCE: src_cfg = cfg_data[7:0];
					CFG_TIMEOUT_MS:      timeout_cfg = cfg_data;
					CFG_AGE_CEILING:     ceiling_cfg = cfg_data;
					default: ;
				endcase
			end
			// Every accepted input beat yields exactly one report.
			if (s_tvalid && s_tready) begin
				compute_sensor_report(s_tuser, s_tdata, fresh_rep);
				pending_reports.push_back(fresh_rep);
			end
		end
		reports_due = pending_reports.size();
	end

endmodule

[tb/sv/optical_flow_frame_receiver_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Optical flow frame receiver testbench
// Drives serial bytes and millisecond ticks into the receiver under five
// register settings. The run opens with a short directed part, followed by
// mostly well-formed random frames mixed with noise, broken frames and ticks.
// Both sides stall in random bursts outside the last setting. The checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module optical_flow_frame_receiver_tb;
	import ofr_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_BEATS    = 230;

	logic           clk = 1'b0;
	logic           arst_n;
	logic           cfg_en;
	logic [1:0]     cfg_index;
	logic [13:0]    cfg_data;
	logic           s_tvalid;
	logic           s_tready;
	logic [15:0]    s_tdata;   // byte_value[7:0], tick_ms[15:8]
	logic           s_tuser;   // req_type
	logic           m_tvalid;
	logic           m_tready;
	logic [135:0]   m_tdata;   // report fields from bit 0 up

	int             error_count;
	int             reports_due;
	int             reports_checked;
	int             frames_ok;
	int             frames_bad;
	int             ok_reports;

	bit             quiet = 1'b0;
	bit             sender_gaps = 1'b1;
	bit             receiver_gaps = 1'b1;
	int             beats_sent = 0;
	int             idle_cycles = 0;
	int             receiver_hold;
	logic [7:0]     cur_src;
	logic [7:0]     frame_body [$];

	optical_flow_frame_receiver u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	ofr_frame_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_en          (cfg_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.error_count     (error_count),
		.reports_due     (reports_due),
		.reports_checked (reports_checked),
		.frames_ok       (frames_ok),
		.frames_bad      (frames_bad),
		.ok_reports      (ok_reports)
	);

	always #1 clk = ~clk;

	// Stop the run if no beat moves on either stream for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat accepted for %0d cycles", idle_cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result side: ready drops in random bursts, with calm stretches between them.
	initial begin
		m_tready = 1'b0;
		receiver_hold = 0;
		forever begin
			@(negedge clk);
			if (quiet)
				receiver_gaps = 1'b0;
			else if ($urandom_range(0, 63) == 0)
				receiver_gaps = !receiver_gaps;
			if (receiver_hold > 0) begin
				m_tready = 1'b0;
				receiver_hold--;
			end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
				m_tready = 1'b0;
				receiver_hold = $urandom_range(1, 11) - 1;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	function automatic logic [7:0] random_tick();
		if ($urandom_range(0, 1) == 0)
			return $urandom_range(0, 15);
		return $urandom_range(0, 255);
	endfunction

	// Offer one beat and hold it until it is taken; the unused field is random.
	task automatic push_beat(input logic req, input logic [7:0] value);
		logic [7:0] spare;
		spare = $urandom_range(0, 255);
		if (sender_gaps && $urandom_range(0, 9) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = req;
		s_tdata = (req == REQ_TICK) ? {value, spare} : {spare, value};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		beats_sent++;
	endtask

	// Send header, frame_body and checksum; a broken frame is cut short and
	// ends in a random byte. Ticks may slip in between bytes.
	task automatic send_frame(input logic [7:0] src, input logic [7:0] dst,
			input logic [7:0] fn, input bit csum_good, input bit broken);
		logic [7:0] frame_bytes [$];
		logic [7:0] sum;
		logic [7:0] len_byte;
		logic [7:0] flip;
		int         cut;
		len_byte = frame_body.size();
		frame_bytes = {HDR_BYTE, src, dst, fn, len_byte};
		foreach (frame_body[i])
			frame_bytes.push_back(frame_body[i]);
		sum = '0;
		foreach (frame_bytes[i])
			sum += frame_bytes[i];
		flip = $urandom_range(1, 255);
		frame_bytes.push_back(csum_good ? sum : sum ^ flip);
		if (broken) begin
			cut = $urandom_range(1, frame_bytes.size() - 1);
			while (frame_bytes.size() > cut)
				void'(frame_bytes.pop_back());
			frame_bytes.push_back($urandom_range(0, 255));
		end
		foreach (frame_bytes[i]) begin
			if (!quiet && $urandom_range(0, 24) == 0)
				push_beat(REQ_TICK, random_tick());
			push_beat(REQ_BYTE, frame_bytes[i]);
		end
	endtask

	// Hold off the sender until every expected report has come back.
	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (reports_due != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [13:0] value);
		cfg_en = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_en = 1'b0;
	endtask

	initial begin
		logic [7:0]  fn;
		logic [7:0]  sel;
		logic [7:0]  src;
		logic [13:0] tmo;
		logic [13:0] ceiling_val;
		int          len;
		int          pick;
		int          phase_no;
		bit          paused_once;

		arst_n = 1'b0;
		cfg_en = 1'b0;
		cfg_index = CFG_EXPECTED_SOURCE;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = REQ_BYTE;
		cur_src = SOURCE_RESET;
		paused_once = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (phase_no = 0; phase_no < 5; phase_no++) begin
			if (phase_no == 0) begin
				// Ticks at both extremes, with ages already at the ceiling.
				push_beat(REQ_TICK, 8'hFF);
				push_beat(REQ_TICK, 8'h00);
				// A stray byte while idle, then a header with the wrong source.
				push_beat(REQ_BYTE, 8'h00);
				push_beat(REQ_BYTE, HDR_BYTE);
				push_beat(REQ_BYTE, 8'h00);
				// Zero length: the following header byte is eaten, not restarted on.
				push_beat(REQ_BYTE, HDR_BYTE);
				push_beat(REQ_BYTE, SOURCE_RESET);
				push_beat(REQ_BYTE, 8'h00);
				push_beat(REQ_BYTE, FN_FLOW);
				push_beat(REQ_BYTE, 8'h00);
				push_beat(REQ_BYTE, HDR_BYTE);
				// Short raw flow frame: light level falls past the payload, reads zero.
				frame_body = {SEL_RAW, 8'hFF, 8'h7F, 8'h80};
				send_frame(SOURCE_RESET, 8'hFF, FN_FLOW, 1'b1, 1'b0);
				// Raw altitude frame with a bad checksum changes nothing.
				frame_body = {SEL_RAW, 8'hFF, 8'hFF};
				send_frame(SOURCE_RESET, 8'h00, FN_ALT, 1'b0, 1'b0);
			end else begin
				wait_drained();
				case (phase_no)
					1: begin
						src = 8'h00;
						tmo = 14'd0;
						ceiling_val = 14'd0;
					end
					2: begin
						src = 8'hFF;
						tmo = 14'd16383;
						ceiling_val = 14'd16383;
					end
					3: begin
						src = HDR_BYTE;
						tmo = $urandom_range(0, 600);
						ceiling_val = $urandom_range(0, 2000);
					end
					default: begin
						src = $urandom_range(0, 255);
						tmo = $urandom_range(20, 400);
						ceiling_val = $urandom_range(500, 16383);
						quiet = 1'b1;
					end
				endcase
				write_reg(CFG_EXPECTED_SOURCE, {6'd0, src});
				write_reg(CFG_TIMEOUT_MS, tmo);
				write_reg(CFG_AGE_CEILING, ceiling_val);
				cur_src = src;
			end

			// Random part: mostly framed traffic, some ticks and stray bytes.
			while (beats_sent < 30 + (phase_no + 1) * PHASE_BEATS) begin
				sender_gaps = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
				if (phase_no == 2 && !paused_once && beats_sent > 30 + 2 * PHASE_BEATS + 100) begin
					wait_drained();
					paused_once = 1'b1;
				end
				pick = $urandom_range(0, 99);
				if (pick < 12) begin
					push_beat(REQ_TICK, random_tick());
				end else if (pick < 20) begin
					push_beat(REQ_BYTE, $urandom_range(0, 255));
				end else begin
					pick = $urandom_range(0, 9);
					fn = (pick < 4) ? FN_FLOW : (pick < 8) ? FN_ALT : $urandom_range(0, 255);
					pick = $urandom_range(0, 19);
					sel = (pick < 9) ? SEL_RAW : (pick < 18) ? SEL_FUSED : $urandom_range(0, 255);
					pick = $urandom_range(0, 99);
					if (pick < 6)
						len = 0;
					else if (pick < 12)
						len = $urandom_range(16, 40);
					else if (pick < 13)
						len = $urandom_range(200, 255);
					else if (pick < 60)
						len = (fn == FN_FLOW) ? ((sel == SEL_FUSED) ? CAP_DEPTH : 5) : 3;
					else
						len = $urandom_range(1, CAP_DEPTH);
					frame_body.delete();
					for (int i = 0; i < len; i++)
						frame_body.push_back((i == 0) ? sel : $urandom_range(0, 255));
					src = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : cur_src;
					send_frame(src, $urandom_range(0, 255), fn, $urandom_range(0, 9) != 0,
						$urandom_range(0, 14) == 0);
				end
			end
		end

		// Drain the remaining reports, then allow for the pipeline latency.
		wait_drained();
		repeat (8) @(negedge clk);
		$display("Sent %0d input beats over five register settings; checked %0d results.",
			beats_sent, reports_checked);
		$display("Frames accepted: %0d, checksum failures: %0d, results with sensor ok: %0d.",
			frames_ok, frames_bad, ok_reports);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
